>>> hdl/assert_macros.svh
// Assertion macros shared by the script lexer RTL.
// Depends on nothing; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

>>> hdl/slt_pkg.sv
// Types, token codes and keyword table for the script lexer.
// Used by every module of the block; depends on nothing.
package slt_pkg;

   // field widths
   localparam int LINE_COL_BITS = 16;
   localparam int OFFSET_BITS   = 24;
   localparam int LENGTH_BITS   = 16;
   localparam int VALUE_BITS    = 31;
   localparam int KIND_BITS     = 5;
   localparam int KW_BYTES      = 7;
   localparam int KW_BITS       = 8 * KW_BYTES;
   localparam int KW_COUNT      = 13;

   // longest identifier before it is split; always longer than any keyword
   localparam logic [LENGTH_BITS-1:0] IDENT_MAX_BYTES = LENGTH_BITS'(255);
   localparam logic [LENGTH_BITS-1:0] KW_PREFIX_LEN   = LENGTH_BITS'(KW_BYTES);
   localparam logic [VALUE_BITS-1:0]  NUM_MAX         = '1;

   // queue depths
   localparam int CMD_DEPTH     = 4;
   localparam int CMD_PTR_BITS  = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_BITS  = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH     = 4;
   localparam int RSP_PTR_BITS  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS  = $clog2(RSP_DEPTH + 1);

   typedef logic [KIND_BITS-1:0]     kind_type;
   typedef logic [VALUE_BITS-1:0]    value_type;
   typedef logic [LINE_COL_BITS-1:0] linecol_type;
   typedef logic [OFFSET_BITS-1:0]   offset_type;
   typedef logic [LENGTH_BITS-1:0]   length_type;

   // token kinds
   localparam kind_type KIND_EOF      = 5'd0;
   localparam kind_type KIND_NUMBER   = 5'd1;
   localparam kind_type KIND_ASSIGN   = 5'd2;
   localparam kind_type KIND_LET      = 5'd3;
   localparam kind_type KIND_IDENT    = 5'd4;
   localparam kind_type KIND_PLUS     = 5'd5;
   localparam kind_type KIND_MINUS    = 5'd6;
   localparam kind_type KIND_STAR     = 5'd7;
   localparam kind_type KIND_COMMA    = 5'd8;
   localparam kind_type KIND_SLASH    = 5'd9;
   localparam kind_type KIND_LPAREN   = 5'd10;
   localparam kind_type KIND_RPAREN   = 5'd11;
   localparam kind_type KIND_NEWLINE  = 5'd12;
   localparam kind_type KIND_PRINTF   = 5'd13;
   localparam kind_type KIND_INPUT    = 5'd14;
   localparam kind_type KIND_STR_END  = 5'd15;
   localparam kind_type KIND_RAND     = 5'd16;
   localparam kind_type KIND_LEN      = 5'd17;
   localparam kind_type KIND_CLEAR    = 5'd18;
   localparam kind_type KIND_ABS      = 5'd19;
   localparam kind_type KIND_EXIT     = 5'd20;
   localparam kind_type KIND_SQRT     = 5'd21;
   localparam kind_type KIND_SLEEP    = 5'd22;
   localparam kind_type KIND_TYPENAME = 5'd23;
   localparam kind_type KIND_UPPER    = 5'd24;
   localparam kind_type KIND_LOWER    = 5'd25;
   localparam kind_type KIND_STR_CHAR = 5'd26;
   localparam kind_type KIND_BAD_CHAR = 5'd27;
   localparam kind_type KIND_UNTERM   = 5'd28;

   // keyword table, packed right-aligned as the prefix register holds them
   localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
      {32'd0, "let"},  {8'd0, "printf"}, {16'd0, "input"}, {24'd0, "rand"},
      {32'd0, "len"},  {16'd0, "clear"}, {32'd0, "abs"},   {24'd0, "exit"},
      {24'd0, "sqrt"}, {16'd0, "sleep"}, {24'd0, "type"},  {16'd0, "upper"},
      {16'd0, "lower"}
   };
   localparam length_type KW_LEN [KW_COUNT] = '{
      16'd3, 16'd6, 16'd5, 16'd4, 16'd3, 16'd5, 16'd3, 16'd4, 16'd4, 16'd5,
      16'd4, 16'd5, 16'd5
   };
   localparam kind_type KW_KIND [KW_COUNT] = '{
      KIND_LET, KIND_PRINTF, KIND_INPUT, KIND_RAND, KIND_LEN, KIND_CLEAR,
      KIND_ABS, KIND_EXIT, KIND_SQRT, KIND_SLEEP, KIND_TYPENAME, KIND_UPPER,
      KIND_LOWER
   };

   // byte classes decided by the front end
   typedef enum logic [3:0] {
      CLS_SPACE,
      CLS_HASH,
      CLS_QUOTE,
      CLS_OPER,
      CLS_NEWLINE,
      CLS_DIGIT,
      CLS_ALPHA,
      CLS_BSLASH,
      CLS_OTHER
   } cls_type;

   // scanner modes
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_IDENT,
      MODE_COMMENT,
      MODE_STRING,
      MODE_ESCAPE
   } mode_type;

   // classified item between front and back
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
      cls_type    cls;
      kind_type   op_kind;
      logic [7:0] esc_char;
   } cmd_type;

   // one result item
   typedef struct packed {
      kind_type    kind;
      value_type   value;
      linecol_type line;
      linecol_type column;
      offset_type  offset;
      length_type  length;
      logic        last;
   } res_type;

   // up to two results written by the back end in one cycle
   typedef struct packed {
      logic [1:0] count;
      res_type    first;
      res_type    second;
   } push_type;

   // identifier or keyword kind from the packed prefix and the byte count
   function automatic kind_type ident_kind(input logic [KW_BITS-1:0] prefix,
                                           input length_type len);
      kind_type k;
      k = KIND_IDENT;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (len == KW_LEN[i] && prefix == KW_TEXT[i]) begin
            k = KW_KIND[i];
         end
      end
      return k;
   endfunction

   // result record with the last flag cleared
   function automatic res_type make_res(input kind_type kind, input value_type value,
                                        input linecol_type line, input linecol_type column,
                                        input offset_type offset, input length_type length);
      res_type r;
      r.kind   = kind;
      r.value  = value;
      r.line   = line;
      r.column = column;
      r.offset = offset;
      r.length = length;
      r.last   = 1'b0;
      return r;
   endfunction

endpackage

>>> hdl/slt_front.sv
// Front end of the script lexer: classifies each source byte and queues it.
// Depends on slt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slt_front
   import slt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_pop
);

   cmd_type                 cmd_mem_ff [CMD_DEPTH];
   logic [CMD_PTR_BITS-1:0] cmd_wr_ff, cmd_wr_in;
   logic [CMD_PTR_BITS-1:0] cmd_rd_ff, cmd_rd_in;
   logic [CMD_CNT_BITS-1:0] cmd_count_ff, cmd_count_in;
   logic                    cmd_write;
   logic                    cmd_read;
   cmd_type                 cmd_new;

   // byte classification
   function automatic cls_type classify(input logic [7:0] b);
      cls_type c;
      if (b == " " || b == 8'h09 || b == 8'h0D) begin
         c = CLS_SPACE;
      end else if (b == "#") begin
         c = CLS_HASH;
      end else if (b == 8'h22) begin
         c = CLS_QUOTE;
      end else if (b == 8'h0A) begin
         c = CLS_NEWLINE;
      end else if (b == "+" || b == "-" || b == "*" || b == "," || b == "/" ||
                   b == "(" || b == ")" || b == "=") begin
         c = CLS_OPER;
      end else if (b >= "0" && b <= "9") begin
         c = CLS_DIGIT;
      end else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" ||
                   b[7]) begin
         c = CLS_ALPHA;
      end else if (b == 8'h5C) begin
         c = CLS_BSLASH;
      end else begin
         c = CLS_OTHER;
      end
      return c;
   endfunction

   // token kind of a single-byte operator or newline
   function automatic kind_type oper_kind(input logic [7:0] b);
      kind_type k;
      case (b)
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         ",":     k = KIND_COMMA;
         "/":     k = KIND_SLASH;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "=":     k = KIND_ASSIGN;
         8'h0A:   k = KIND_NEWLINE;
         default: k = KIND_EOF;
      endcase
      return k;
   endfunction

   // decoded character after a backslash
   function automatic logic [7:0] escape_char(input logic [7:0] b);
      logic [7:0] e;
      case (b)
         "n":     e = 8'h0A;
         "t":     e = 8'h09;
         default: e = b;
      endcase
      return e;
   endfunction

   // classify on the way in
   always_comb begin
      cmd_new.text_byte   = req_text_byte;
      cmd_new.end_of_text = req_end_of_text;
      cmd_new.cls         = classify(req_text_byte);
      cmd_new.op_kind     = oper_kind(req_text_byte);
      cmd_new.esc_char    = escape_char(req_text_byte);
   end

   // queue control
   assign req_full  = (cmd_count_ff == CMD_CNT_BITS'(CMD_DEPTH));
   assign cmd_valid = (cmd_count_ff != '0);
   assign cmd_write = req_push && !req_full;
   assign cmd_read  = cmd_pop && cmd_valid;
   assign cmd       = cmd_mem_ff[cmd_rd_ff];

   always_comb begin
      cmd_wr_in    = cmd_write ? cmd_wr_ff + 1'b1 : cmd_wr_ff;
      cmd_rd_in    = cmd_read ? cmd_rd_ff + 1'b1 : cmd_rd_ff;
      cmd_count_in = cmd_count_ff + CMD_CNT_BITS'(cmd_write) - CMD_CNT_BITS'(cmd_read);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_wr_ff    <= '0;
         cmd_rd_ff    <= '0;
         cmd_count_ff <= '0;
      end else begin
         cmd_wr_ff    <= cmd_wr_in;
         cmd_rd_ff    <= cmd_rd_in;
         cmd_count_ff <= cmd_count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (cmd_write) begin
         cmd_mem_ff[cmd_wr_ff] <= cmd_new;
      end
   end

   `ASSERT_NEVER(a_cmd_underflow, clock, reset, cmd_pop && !cmd_valid, "back end took an item from an empty queue")

endmodule

>>> hdl/slt_back.sv
// Back end of the script lexer: the scanning state machine and position counters.
// Depends on slt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slt_back
   import slt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     cmd_valid,
   input  cmd_type  cmd,
   output logic     cmd_pop,
   input  logic     rsp_room,
   output push_type rsp_push
);

   mode_type          mode_ff, mode_in;
   logic              err_ff, err_in;
   linecol_type       line_ff, line_in;
   linecol_type       col_ff, col_in;
   offset_type        off_ff, off_in;
   linecol_type       tline_ff, tline_in;
   linecol_type       tcol_ff, tcol_in;
   offset_type        toff_ff, toff_in;
   length_type        cnt_ff, cnt_in;
   value_type         acc_ff, acc_in;
   logic [KW_BITS-1:0] kw_ff, kw_in;

   logic              take;
   logic              a_valid, b_valid, do_idle;
   res_type           a_res, b_res;
   logic [VALUE_BITS+3:0] acc_next;
   length_type        cnt_inc;
   value_type         byte_value;
   value_type         esc_value;

   assign take    = cmd_valid && rsp_room;
   assign cmd_pop = take;

   // shared arithmetic: times ten plus digit, saturating byte count
   assign acc_next   = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                       {(VALUE_BITS + 0)'(0), cmd.text_byte[3:0]};
   assign cnt_inc    = (cnt_ff == '1) ? cnt_ff : cnt_ff + 1'b1;
   assign byte_value = {(VALUE_BITS - 8)'(0), cmd.text_byte};
   assign esc_value  = {(VALUE_BITS - 8)'(0), cmd.esc_char};

   // next state and results
   always_comb begin
      mode_in  = mode_ff;
      err_in   = err_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      off_in   = off_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      toff_in  = toff_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      kw_in    = kw_ff;
      a_valid  = 1'b0;
      b_valid  = 1'b0;
      do_idle  = 1'b0;
      a_res    = make_res(KIND_IDENT, '0, tline_ff, tcol_ff, toff_ff, cnt_ff);
      b_res    = make_res(KIND_EOF, '0, line_ff, col_ff, off_ff, '0);

      if (cmd.end_of_text) begin
         // flush the pending token, then EOF at the current position
         case (mode_ff)
            MODE_NUMBER: begin
               a_valid = 1'b1;
               a_res   = make_res(KIND_NUMBER, acc_ff, tline_ff, tcol_ff, toff_ff, cnt_ff);
            end
            MODE_IDENT: begin
               a_valid = 1'b1;
               a_res   = make_res(ident_kind(kw_ff, cnt_ff), '0, tline_ff, tcol_ff,
                                  toff_ff, cnt_ff);
            end
            MODE_STRING, MODE_ESCAPE: begin
               a_valid = 1'b1;
               a_res   = make_res(KIND_UNTERM, '0, line_ff, col_ff, off_ff, '0);
            end
            default: begin
               a_valid = 1'b0;
            end
         endcase
         b_valid  = 1'b1;
         mode_in  = MODE_IDLE;
         err_in   = 1'b0;
         line_in  = LINE_COL_BITS'(1);
         col_in   = LINE_COL_BITS'(1);
         off_in   = '0;
         tline_in = LINE_COL_BITS'(1);
         tcol_in  = LINE_COL_BITS'(1);
         toff_in  = '0;
         cnt_in   = '0;
         acc_in   = '0;
         kw_in    = '0;
      end else begin
         if (!err_ff) begin
            case (mode_ff)
               MODE_NUMBER: begin
                  if (cmd.cls == CLS_DIGIT) begin
                     acc_in = (acc_next > {4'b0000, NUM_MAX}) ? NUM_MAX
                                                               : acc_next[VALUE_BITS-1:0];
                     cnt_in = cnt_inc;
                  end else begin
                     a_valid = 1'b1;
                     a_res   = make_res(KIND_NUMBER, acc_ff, tline_ff, tcol_ff, toff_ff,
                                        cnt_ff);
                     do_idle = 1'b1;
                  end
               end
               MODE_IDENT: begin
                  if (cmd.cls == CLS_ALPHA || cmd.cls == CLS_DIGIT) begin
                     if (cnt_ff < KW_PREFIX_LEN) begin
                        kw_in = {kw_ff[KW_BITS-9:0], cmd.text_byte};
                     end
                     cnt_in = cnt_inc;
                     // split a long run; it is longer than any keyword
                     if (cnt_inc >= IDENT_MAX_BYTES) begin
                        a_valid = 1'b1;
                        a_res   = make_res(KIND_IDENT, '0, tline_ff, tcol_ff, toff_ff,
                                           cnt_inc);
                        mode_in = MODE_IDLE;
                     end
                  end else begin
                     a_valid = 1'b1;
                     a_res   = make_res(ident_kind(kw_ff, cnt_ff), '0, tline_ff, tcol_ff,
                                        toff_ff, cnt_ff);
                     do_idle = 1'b1;
                  end
               end
               MODE_COMMENT: begin
                  if (cmd.cls == CLS_NEWLINE) begin
                     b_valid = 1'b1;
                     b_res   = make_res(KIND_NEWLINE, '0, line_ff, col_ff, off_ff,
                                        LENGTH_BITS'(1));
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_STRING: begin
                  if (cmd.cls == CLS_QUOTE) begin
                     a_valid = 1'b1;
                     a_res   = make_res(KIND_STR_END, '0, tline_ff, tcol_ff, toff_ff,
                                        cnt_ff);
                     mode_in = MODE_IDLE;
                  end else if (cmd.cls == CLS_BSLASH) begin
                     mode_in = MODE_ESCAPE;
                  end else begin
                     b_valid = 1'b1;
                     b_res   = make_res(KIND_STR_CHAR, byte_value, line_ff, col_ff, off_ff,
                                        LENGTH_BITS'(1));
                     cnt_in  = cnt_inc;
                  end
               end
               MODE_ESCAPE: begin
                  b_valid = 1'b1;
                  b_res   = make_res(KIND_STR_CHAR, esc_value, line_ff, col_ff, off_ff,
                                     LENGTH_BITS'(2));
                  cnt_in  = cnt_inc;
                  mode_in = MODE_STRING;
               end
               default: begin
                  do_idle = 1'b1;
               end
            endcase

            // byte seen between tokens
            if (do_idle) begin
               mode_in = MODE_IDLE;
               case (cmd.cls)
                  CLS_SPACE: begin
                     mode_in = MODE_IDLE;
                  end
                  CLS_HASH: begin
                     mode_in = MODE_COMMENT;
                  end
                  CLS_QUOTE: begin
                     tline_in = line_ff;
                     tcol_in  = col_ff;
                     toff_in  = off_ff;
                     cnt_in   = '0;
                     acc_in   = '0;
                     kw_in    = '0;
                     mode_in  = MODE_STRING;
                  end
                  CLS_OPER, CLS_NEWLINE: begin
                     b_valid = 1'b1;
                     b_res   = make_res(cmd.op_kind, '0, line_ff, col_ff, off_ff,
                                        LENGTH_BITS'(1));
                  end
                  CLS_DIGIT: begin
                     tline_in = line_ff;
                     tcol_in  = col_ff;
                     toff_in  = off_ff;
                     cnt_in   = LENGTH_BITS'(1);
                     acc_in   = {(VALUE_BITS - 4)'(0), cmd.text_byte[3:0]};
                     kw_in    = '0;
                     mode_in  = MODE_NUMBER;
                  end
                  CLS_ALPHA: begin
                     tline_in = line_ff;
                     tcol_in  = col_ff;
                     toff_in  = off_ff;
                     cnt_in   = LENGTH_BITS'(1);
                     acc_in   = '0;
                     kw_in    = {(KW_BITS - 8)'(0), cmd.text_byte};
                     mode_in  = MODE_IDENT;
                  end
                  default: begin
                     b_valid = 1'b1;
                     b_res   = make_res(KIND_BAD_CHAR, byte_value, line_ff, col_ff, off_ff,
                                        LENGTH_BITS'(1));
                     err_in  = 1'b1;
                  end
               endcase
            end
         end

         // position advances even while stopped on an error
         if (cmd.cls == CLS_NEWLINE) begin
            line_in = (line_ff == '1) ? line_ff : line_ff + 1'b1;
            col_in  = LINE_COL_BITS'(1);
         end else begin
            col_in  = (col_ff == '1) ? col_ff : col_ff + 1'b1;
         end
         off_in = off_ff + 1'b1;
      end
   end

   // pack results in order, last flag on the final one
   always_comb begin
      rsp_push.first  = a_res;
      rsp_push.second = b_res;
      rsp_push.count  = 2'd0;
      if (take) begin
         if (a_valid && b_valid) begin
            rsp_push.count       = 2'd2;
            rsp_push.second.last = 1'b1;
         end else if (a_valid) begin
            rsp_push.count      = 2'd1;
            rsp_push.first.last = 1'b1;
         end else if (b_valid) begin
            rsp_push.count      = 2'd1;
            rsp_push.first      = b_res;
            rsp_push.first.last = 1'b1;
         end
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         err_ff   <= 1'b0;
         line_ff  <= LINE_COL_BITS'(1);
         col_ff   <= LINE_COL_BITS'(1);
         off_ff   <= '0;
         tline_ff <= LINE_COL_BITS'(1);
         tcol_ff  <= LINE_COL_BITS'(1);
         toff_ff  <= '0;
         cnt_ff   <= '0;
         acc_ff   <= '0;
         kw_ff    <= '0;
      end else if (take) begin
         mode_ff  <= mode_in;
         err_ff   <= err_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         off_ff   <= off_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
         toff_ff  <= toff_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         kw_ff    <= kw_in;
      end
   end

   `ASSERT_CLK(a_eof_clears, clock, reset, (take && cmd.end_of_text) |=> (mode_ff == MODE_IDLE && !err_ff && off_ff == '0), "end of text did not return the scanner to its reset state")
   `ASSERT_CLK(a_last_order, clock, reset, (rsp_push.count == 2'd2) |-> (!rsp_push.first.last && rsp_push.second.last), "two results written with the last flag misplaced")

endmodule

>>> hdl/slt_rsp_fifo.sv
// Result queue of the script lexer: two writes and one read per cycle.
// Depends on slt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module slt_rsp_fifo
   import slt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type rsp_push,
   output logic     rsp_room,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output res_type  rsp_head
);

   res_type                 rsp_mem_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] rsp_wr_ff, rsp_wr_in;
   logic [RSP_PTR_BITS-1:0] rsp_rd_ff, rsp_rd_in;
   logic [RSP_CNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic [RSP_PTR_BITS-1:0] rsp_wr_next;
   logic                    rsp_read;

   // room for a byte that gives two results
   assign rsp_room    = (rsp_count_ff <= RSP_CNT_BITS'(RSP_DEPTH - 2));
   assign rsp_empty   = (rsp_count_ff == '0);
   assign rsp_read    = rsp_pop && !rsp_empty;
   assign rsp_head    = rsp_mem_ff[rsp_rd_ff];
   assign rsp_wr_next = rsp_wr_ff + 1'b1;

   always_comb begin
      rsp_wr_in    = rsp_wr_ff + RSP_PTR_BITS'(rsp_push.count);
      rsp_rd_in    = rsp_read ? rsp_rd_ff + 1'b1 : rsp_rd_ff;
      rsp_count_in = rsp_count_ff + RSP_CNT_BITS'(rsp_push.count) -
                     RSP_CNT_BITS'(rsp_read);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_wr_ff    <= '0;
         rsp_rd_ff    <= '0;
         rsp_count_ff <= '0;
      end else begin
         rsp_wr_ff    <= rsp_wr_in;
         rsp_rd_ff    <= rsp_rd_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   // storage, written in result order
   always_ff @(posedge clock) begin
      if (rsp_push.count != 2'd0) begin
         rsp_mem_ff[rsp_wr_ff] <= rsp_push.first;
      end
      if (rsp_push.count == 2'd2) begin
         rsp_mem_ff[rsp_wr_next] <= rsp_push.second;
      end
   end

   `ASSERT_NEVER(a_rsp_overflow, clock, reset, rsp_push.count != 2'd0 && !rsp_room, "results written without room in the queue")

endmodule

>>> hdl/script_lexer_tokenizer_unit.sv
// Script lexer: one source byte per cycle goes in, classified and queued by the front end,
// scanned by the back end, and the resulting tokens leave through a four-entry result queue.
// A byte is taken every cycle while req_full is low; the scanning state machine handles
// one byte per cycle and writes up to two results at once, so throughput is one byte per
// cycle as long as results are popped at least as fast as they are made, one per cycle.
// The scanner waits whenever the result queue has fewer than two free entries.
// The results of a byte reach the result queue through the input queue, then the scanner.
// A byte that ends a pending number or identifier and is itself an operator, newline or bad
// character gives two results, as does an end of text that flushes a token or an open string;
// the second is flagged last_of_run. No clearing pass is needed after reset.
// Depends on slt_pkg, slt_front, slt_back and slt_rsp_fifo.
module script_lexer_tokenizer_unit
   import slt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [7:0]               req_text_byte,
   input  logic                     req_end_of_text,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [KIND_BITS-1:0]     rsp_token_kind,
   output logic [VALUE_BITS-1:0]    rsp_token_value,
   output logic [LINE_COL_BITS-1:0] rsp_start_line,
   output logic [LINE_COL_BITS-1:0] rsp_start_column,
   output logic [OFFSET_BITS-1:0]   rsp_start_offset,
   output logic [LENGTH_BITS-1:0]   rsp_token_length,
   output logic                     rsp_last_of_run
);

   logic     cmd_valid;
   cmd_type  cmd;
   logic     cmd_pop;
   logic     rsp_room;
   push_type rsp_push;
   res_type  rsp_head;

   // classify and queue
   slt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   // scanning state machine
   slt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_room  (rsp_room),
      .rsp_push  (rsp_push)
   );

   // result queue
   slt_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .rsp_push  (rsp_push),
      .rsp_room  (rsp_room),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_head  (rsp_head)
   );

   // result fields
   assign rsp_token_kind   = rsp_head.kind;
   assign rsp_token_value  = rsp_head.value;
   assign rsp_start_line   = rsp_head.line;
   assign rsp_start_column = rsp_head.column;
   assign rsp_start_offset = rsp_head.offset;
   assign rsp_token_length = rsp_head.length;
   assign rsp_last_of_run  = rsp_head.last;

endmodule

>>> verif/script_lexer_tokenizer_unit_tb.sv
// Self-checking testbench for the script lexer: feeds source bytes, predicts every token and
// compares each popped result field by field. Depends on slt_pkg and script_lexer_tokenizer_unit.
module script_lexer_tokenizer_unit_tb;
   import slt_pkg::*;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam int QUIET_LIMIT      = 4000;
   localparam int HOLD_LEN         = 300;
   localparam int DRAIN_CYCLES     = 16;
   localparam int RANDOM_PER_PHASE = 85;
   localparam int PRESSURE_ITEMS   = 50;
   localparam int LONG_WORD        = 260;

   typedef struct packed {
      logic [7:0] b;
      logic       eot;
   } src_item_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_push = 1'b0;
   logic                     req_full;
   logic [7:0]               req_text_byte = 8'h00;
   logic                     req_end_of_text = 1'b0;
   logic                     rsp_empty;
   logic                     rsp_pop = 1'b0;
   logic [KIND_BITS-1:0]     rsp_token_kind;
   logic [VALUE_BITS-1:0]    rsp_token_value;
   logic [LINE_COL_BITS-1:0] rsp_start_line;
   logic [LINE_COL_BITS-1:0] rsp_start_column;
   logic [OFFSET_BITS-1:0]   rsp_start_offset;
   logic [LENGTH_BITS-1:0]   rsp_token_length;
   logic                     rsp_last_of_run;

   src_item_type src_items[$];
   res_type  expected_tokens[$];
   int       send_idle_pct = 0;
   int       recv_stall_pct = 0;
   logic     hold_armed = 1'b0;
   int       hold_count;
   logic     recv_hold;
   int       quiet_cycles;
   int       mismatches = 0;
   int       tokens_seen = 0;
   int       bytes_in = 0;
   int       queued_count = 0;

   string kw_words [KW_COUNT] = '{"let", "printf", "input", "rand", "len", "clear", "abs",
                                  "exit", "sqrt", "sleep", "type", "upper", "lower"};
   string op_chars = "+-*,/()=";

   // lexer state mirrored by the predictor
   mode_type           scan_st;
   logic               halted;
   linecol_type        at_line, at_col, tok_line, tok_col;
   offset_type         at_off, tok_off;
   length_type         tok_len;
   value_type          num_val;
   logic [KW_BITS-1:0] word_head;
   res_type            run_out [2];
   int                 run_n;

   script_lexer_tokenizer_unit DUT (.*);

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- token predictor

   function automatic void clear_scanner();
      scan_st   = MODE_IDLE;
      halted    = 1'b0;
      at_line   = linecol_type'(1);
      at_col    = linecol_type'(1);
      at_off    = '0;
      tok_line  = linecol_type'(1);
      tok_col   = linecol_type'(1);
      tok_off   = '0;
      tok_len   = '0;
      num_val   = '0;
      word_head = '0;
   endfunction

   function automatic void emit_token(kind_type k, value_type v, linecol_type ln,
                                      linecol_type col, offset_type off, length_type len);
      if (run_n < 2) begin
         run_out[run_n] = '{kind: k, value: v, line: ln, column: col, offset: off,
                            length: len, last: 1'b0};
         run_n++;
      end
   endfunction

   function automatic void emit_here(kind_type k, value_type v, length_type len);
      emit_token(k, v, at_line, at_col, at_off, len);
   endfunction

   function automatic void emit_pending(kind_type k, value_type v, length_type len);
      emit_token(k, v, tok_line, tok_col, tok_off, len);
   endfunction

   function automatic void open_token();
      tok_line  = at_line;
      tok_col   = at_col;
      tok_off   = at_off;
      tok_len   = '0;
      num_val   = '0;
      word_head = '0;
   endfunction

   function automatic void bump_len();
      if (tok_len != '1) tok_len++;
   endfunction

   function automatic void add_word_byte(logic [7:0] b);
      if (tok_len < KW_BYTES) word_head = {word_head[KW_BITS-9:0], b};
      bump_len();
   endfunction

   function automatic bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic bit starts_word(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b > 8'd127;
   endfunction

   // keyword or plain identifier; only short runs can be keywords
   function automatic kind_type word_kind();
      if (tok_len > KW_BYTES) return KIND_IDENT;
      case (word_head)
         "let":    return KIND_LET;
         "printf": return KIND_PRINTF;
         "input":  return KIND_INPUT;
         "rand":   return KIND_RAND;
         "len":    return KIND_LEN;
         "clear":  return KIND_CLEAR;
         "abs":    return KIND_ABS;
         "exit":   return KIND_EXIT;
         "sqrt":   return KIND_SQRT;
         "sleep":  return KIND_SLEEP;
         "type":   return KIND_TYPENAME;
         "upper":  return KIND_UPPER;
         "lower":  return KIND_LOWER;
         default:  return KIND_IDENT;
      endcase
   endfunction

   // a byte seen between tokens
   function automatic void idle_byte(logic [7:0] b);
      kind_type op;
      bit       is_op;
      is_op = 1'b1;
      op    = KIND_EOF;
      case (b)
         "+":     op = KIND_PLUS;
         "-":     op = KIND_MINUS;
         "*":     op = KIND_STAR;
         ",":     op = KIND_COMMA;
         "/":     op = KIND_SLASH;
         "(":     op = KIND_LPAREN;
         ")":     op = KIND_RPAREN;
         "=":     op = KIND_ASSIGN;
         CH_LF:   op = KIND_NEWLINE;
         default: is_op = 1'b0;
      endcase
      if (b == " " || b == CH_TAB || b == CH_CR) return;
      if (b == "#") begin
         scan_st = MODE_COMMENT;
      end else if (b == CH_QUOTE) begin
         open_token();
         scan_st = MODE_STRING;
      end else if (is_op) begin
         emit_here(op, '0, length_type'(1));
      end else if (is_digit(b)) begin
         open_token();
         num_val = value_type'(b - "0");
         bump_len();
         scan_st = MODE_NUMBER;
      end else if (starts_word(b)) begin
         open_token();
         add_word_byte(b);
         scan_st = MODE_IDENT;
      end else begin
         emit_here(KIND_BAD_CHAR, value_type'(b), length_type'(1));
         halted  = 1'b1;
         scan_st = MODE_IDLE;
      end
   endfunction

   // line and column saturate, the offset wraps
   function automatic void step_position(logic [7:0] b);
      if (b == CH_LF) begin
         if (at_line != '1) at_line++;
         at_col = linecol_type'(1);
      end else if (at_col != '1) begin
         at_col++;
      end
      at_off++;
   endfunction

   // one accepted item: work out its tokens and queue them
   function automatic void lex_byte(logic [7:0] b, logic eot);
      longint unsigned grown;
      run_n = 0;
      if (eot) begin
         case (scan_st)
            MODE_NUMBER:              emit_pending(KIND_NUMBER, num_val, tok_len);
            MODE_IDENT:               emit_pending(word_kind(), '0, tok_len);
            MODE_STRING, MODE_ESCAPE: emit_here(KIND_UNTERM, '0, '0);
            default: ;
         endcase
         emit_here(KIND_EOF, '0, '0);
         clear_scanner();
      end else begin
         if (!halted) begin
            case (scan_st)
               MODE_NUMBER: begin
                  if (is_digit(b)) begin
                     grown = 64'(num_val) * 64'd10 + 64'(b - "0");
                     num_val = (grown > 64'(NUM_MAX)) ? NUM_MAX : value_type'(grown);
                     bump_len();
                  end else begin
                     emit_pending(KIND_NUMBER, num_val, tok_len);
                     scan_st = MODE_IDLE;
                     idle_byte(b);
                  end
               end
               MODE_IDENT: begin
                  if (starts_word(b) || is_digit(b)) begin
                     add_word_byte(b);
                     if (tok_len >= IDENT_MAX_BYTES) begin
                        emit_pending(word_kind(), '0, tok_len);
                        scan_st = MODE_IDLE;
                     end
                  end else begin
                     emit_pending(word_kind(), '0, tok_len);
                     scan_st = MODE_IDLE;
                     idle_byte(b);
                  end
               end
               MODE_COMMENT: begin
                  if (b == CH_LF) begin
                     emit_here(KIND_NEWLINE, '0, length_type'(1));
                     scan_st = MODE_IDLE;
                  end
               end
               MODE_STRING: begin
                  if (b == CH_QUOTE) begin
                     emit_pending(KIND_STR_END, '0, tok_len);
                     scan_st = MODE_IDLE;
                  end else if (b == CH_BSLASH) begin
                     scan_st = MODE_ESCAPE;
                  end else begin
                     emit_here(KIND_STR_CHAR, value_type'(b), length_type'(1));
                     bump_len();
                  end
               end
               MODE_ESCAPE: begin
                  emit_here(KIND_STR_CHAR,
                            value_type'(b == "n" ? CH_LF : (b == "t" ? CH_TAB : b)),
                            length_type'(2));
                  bump_len();
                  scan_st = MODE_STRING;
               end
               default: idle_byte(b);
            endcase
         end
         step_position(b);
      end
      if (run_n > 0) run_out[run_n-1].last = 1'b1;
      for (int i = 0; i < run_n; i++) expected_tokens.push_back(run_out[i]);
      bytes_in++;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("token %0d %s: got %0d, expected %0d",
                                   tokens_seen, name, got, want));
   endtask

   task automatic check_token();
      res_type want;
      if (expected_tokens.size() == 0) begin
         report_mismatch($sformatf("token %0d arrived with nothing expected (kind %0d)",
                                   tokens_seen, rsp_token_kind));
      end else begin
         want = expected_tokens.pop_front();
         check_field("kind",   32'(rsp_token_kind),   32'(want.kind));
         check_field("value",  32'(rsp_token_value),  32'(want.value));
         check_field("line",   32'(rsp_start_line),   32'(want.line));
         check_field("column", 32'(rsp_start_column), 32'(want.column));
         check_field("offset", 32'(rsp_start_offset), 32'(want.offset));
         check_field("length", 32'(rsp_token_length), 32'(want.length));
         check_field("last",   32'(rsp_last_of_run),  32'(want.last));
      end
      tokens_seen++;
   endtask

   // ---------------------------------------------------------------- driver and monitor

   // byte driver, fed from the pending item queue
   always @(posedge clock) begin
      src_item_type nxt;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) lex_byte(req_text_byte, req_end_of_text);
         if (req_push && req_full) begin
            // hold the offered item until it is taken
         end else if (src_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = src_items.pop_front();
            req_push        <= 1'b1;
            req_text_byte   <= nxt.b;
            req_end_of_text <= nxt.eot;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // token monitor with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_token();
         rsp_pop <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off, counted once armed
   always @(posedge clock) begin
      if (reset) begin
         hold_count <= 0;
      end else if (hold_armed && hold_count < HOLD_LEN) begin
         hold_count <= hold_count + 1;
      end
   end
   assign recv_hold = hold_armed && hold_count < HOLD_LEN;

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic void add_byte(logic [7:0] b);
      src_items.push_back('{b: b, eot: 1'b0});
      queued_count++;
   endfunction

   function automatic void add_eot();
      src_items.push_back('{b: 8'($urandom_range(255)), eot: 1'b1});
      queued_count++;
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic logic [7:0] rand_word_byte(bit lead);
      case ($urandom_range(5))
         0, 1:    return "a" + 8'($urandom_range(25));
         2:       return "A" + 8'($urandom_range(25));
         3:       return "_";
         4:       return 8'($urandom_range(255, 128));
         default: return lead ? "z" : "0" + 8'($urandom_range(9));
      endcase
   endfunction

   // plain or escaped character inside a string
   function automatic void add_string_char();
      logic [7:0] c;
      if ($urandom_range(3) == 0) begin
         add_byte(CH_BSLASH);
         case ($urandom_range(4))
            0:       add_byte("n");
            1:       add_byte("t");
            2:       add_byte(CH_QUOTE);
            3:       add_byte(CH_LF);
            default: add_byte(8'($urandom_range(255)));
         endcase
      end else begin
         c = 8'($urandom_range(255));
         add_byte((c == CH_QUOTE || c == CH_BSLASH) ? "q" : c);
      end
   endfunction

   // one random source fragment, mostly well formed
   function automatic void rand_piece();
      int         sel;
      int         len;
      logic [7:0] c;
      sel = $urandom_range(99);
      if (sel < 15) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(14, 10) : $urandom_range(6, 1);
         repeat (len) add_byte("0" + 8'($urandom_range(9)));
      end else if (sel < 28) begin
         len = $urandom_range(8, 1);
         add_byte(rand_word_byte(1'b1));
         repeat (len - 1) add_byte(rand_word_byte(1'b0));
      end else if (sel < 38) begin
         add_text(kw_words[$urandom_range(KW_COUNT - 1)]);
         if ($urandom_range(3) == 0) add_byte(rand_word_byte(1'b0));
      end else if (sel < 52) begin
         add_byte(op_chars[$urandom_range(7)]);
      end else if (sel < 62) begin
         repeat ($urandom_range(3, 1)) begin
            case ($urandom_range(2))
               0:       add_byte(" ");
               1:       add_byte(CH_TAB);
               default: add_byte(CH_CR);
            endcase
         end
      end else if (sel < 70) begin
         add_byte(CH_LF);
      end else if (sel < 80) begin
         add_byte(CH_QUOTE);
         repeat ($urandom_range(6)) add_string_char();
         add_byte(CH_QUOTE);
      end else if (sel < 85) begin
         add_byte("#");
         repeat ($urandom_range(8)) begin
            c = 8'($urandom_range(255));
            add_byte(c == CH_LF ? "." : c);
         end
         add_byte(CH_LF);
      end else if (sel < 89) begin
         add_eot();
      end else if (sel < 94) begin
         // string cut off by the end of text, sometimes mid escape
         add_byte(CH_QUOTE);
         repeat ($urandom_range(4)) add_string_char();
         if ($urandom_range(1)) add_byte(CH_BSLASH);
         add_eot();
      end else begin
         // any byte, a short tail that an error would discard, then end of text
         add_byte(8'($urandom_range(255)));
         repeat ($urandom_range(4)) src_items.push_back('{b: 8'($urandom_range(255)), eot: 1'b0});
         add_eot();
      end
   endfunction

   task automatic wait_drained();
      while (src_items.size() != 0 || req_push || expected_tokens.size() != 0)
         @(negedge clock);
   endtask

   task automatic random_phase(int send_pct, int recv_pct);
      @(negedge clock);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      queued_count   = 0;
      while (queued_count < RANDOM_PER_PHASE) begin
         rand_piece();
         if ($urandom_range(1)) add_byte(" ");
      end
      add_eot();
      wait_drained();
   endtask

   initial begin
      clear_scanner();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every operator and keyword, escapes, saturation, errors, flushes at end
      add_eot();
      add_text("let x1=42+(7-3)*5/2,0\n");
      add_text(" \t"); add_byte(CH_CR); add_text("#c"); add_byte(8'hFF); add_byte(CH_LF);
      add_text("2147483648 ");
      add_text("\"a\\n\\t\\\"\\"); add_byte(CH_LF); add_byte(8'h00); add_text("\"");
      add_byte("_"); add_byte(8'hFF); add_text("9"); add_eot();
      add_text("printf input rand len clear abs exit sqrt sleep type upper lower lets");
      add_text("7"); add_eot();
      add_text("\"ab"); add_eot();
      add_text("\"\\"); add_eot();
      add_text("3@zz"); add_eot();
      add_byte(8'h00); add_eot();
      add_text("#x"); add_eot();
      wait_drained();

      // long identifier split at its maximum length, then a comment and a flush
      @(negedge clock);
      add_byte("a");
      repeat (LONG_WORD - 1) add_byte(rand_word_byte(1'b0));
      add_byte(" ");
      add_text(" #\nab");
      add_eot();
      wait_drained();

      // random text under each idling pattern
      random_phase(0, 0);
      random_phase(76, 0);
      random_phase(0, 76);
      random_phase(35, 35);

      // receiver holds off while the sender keeps offering, so the block backs up
      @(negedge clock);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_armed     = 1'b1;
      queued_count   = 0;
      while (queued_count < PRESSURE_ITEMS) rand_piece();
      add_eot();
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("lexed %0d source bytes into %0d checked tokens", bytes_in, tokens_seen);
      $display("covered keywords, escapes, errors, a split identifier and a stalled queue");
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/slt_pkg.sv
hdl/slt_front.sv
hdl/slt_back.sv
hdl/slt_rsp_fifo.sv
hdl/script_lexer_tokenizer_unit.sv
verif/script_lexer_tokenizer_unit_tb.sv
